>>> rtl/pcm_float32_to_int16_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the float32 to int16 PCM converter
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef PCM_FLOAT32_TO_INT16_ASSERT_SVH
`define PCM_FLOAT32_TO_INT16_ASSERT_SVH

// implication checked on every edge outside reset
`define PF_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define PF_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

>>> rtl/pf_pkg.sv
// ---------------------------------------------------------------------------
// pf_pkg
// Types and constants for the float32 to int16 PCM converter.
// ---------------------------------------------------------------------------
package pf_pkg;
	localparam logic [14:0] GAIN = 15'd32767;

	typedef enum logic [1:0] {
		CLS_NORMAL = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_CLAMP  = 2'd2,
		CLS_NAN    = 2'd3
	} cls_t;

	// side-band carried with each item down the pipe
	typedef struct packed {
		logic       neg;
		logic       last;
		cls_t       cls;
		logic [7:0] ex;
	} side_t;
endpackage

>>> rtl/pf_mul.sv
// ---------------------------------------------------------------------------
// pf_mul
// Stage 1: classify sample and form the exact mantissa product.
// ---------------------------------------------------------------------------
module pf_mul import pf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vin,
	input  logic [31:0] sample_bits,
	input  logic        block_end,
	output logic        v_s1,
	output side_t       side_s1,
	output logic [38:0] p_s1
);
	logic [7:0]  ex;
	logic [22:0] fr;
	cls_t        cls;

	assign ex = sample_bits[30:23];
	assign fr = sample_bits[22:0];

	always_comb begin
		if (ex == 8'hFF) cls = (fr != 23'd0) ? CLS_NAN : CLS_CLAMP;
		else if (ex == 8'd0) cls = CLS_ZERO;
		else if (ex > 8'd142) cls = CLS_CLAMP;
		else cls = CLS_NORMAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= vin;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{neg: sample_bits[31], last: block_end, cls: cls, ex: ex};
			p_s1    <= {1'b1, fr} * {24'd0, GAIN};
		end
	end
endmodule

>>> rtl/pf_rnd.sv
// ---------------------------------------------------------------------------
// pf_rnd
// Stage 2: round the product to 24 bits (nearest even), find shift.
// ---------------------------------------------------------------------------
module pf_rnd import pf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_s1,
	input  side_t       side_s1,
	input  logic [38:0] p_s1,
	output logic        v_s2,
	output side_t       side_s2,
	output logic [23:0] q_s2,
	output logic [9:0]  k_s2
);
	logic        hi;
	logic [24:0] q;
	logic [14:0] rem;
	logic [14:0] half;
	logic        up;
	logic [24:0] qr;
	logic [23:0] qf;
	logic [9:0]  k;

	always_comb begin
		hi   = p_s1[38];
		q    = hi ? {1'b0, p_s1[38:15]} : {1'b0, p_s1[37:14]};
		rem  = hi ? p_s1[14:0] : {1'b0, p_s1[13:0]};
		half = hi ? 15'h4000 : 15'h2000;
		up   = (rem > half) || ((rem == half) && q[0]);
		qr   = q + {24'd0, up};
		qf   = qr[24] ? qr[24:1] : qr[23:0];
		k    = {2'b00, side_s1.ex} + (hi ? 10'd15 : 10'd14) + {9'd0, qr[24]} - 10'd150;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			q_s2    <= qf;
			k_s2    <= k;
		end
	end
endmodule

>>> rtl/pf_out.sv
// ---------------------------------------------------------------------------
// pf_out
// Stage 3: shift to integer, round half away, clamp, apply sign.
// ---------------------------------------------------------------------------
module pf_out import pf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_s2,
	input  side_t       side_s2,
	input  logic [23:0] q_s2,
	input  logic [9:0]  k_s2,
	output logic        v_s3,
	output logic [17:0] res_s3
);
	logic [9:0]  sh;
	logic [63:0] qx;
	logic [63:0] lim_p;
	logic [63:0] lim_n;
	logic [63:0] r;
	logic [15:0] val;
	logic        clip;

	always_comb begin
		sh    = -k_s2;
		qx    = {40'd0, q_s2};
		lim_p = {49'd0, 15'h7FFF} << sh[5:0];
		lim_n = {48'd0, 16'h8000} << sh[5:0];
		r     = (qx + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
		val   = 16'd0;
		clip  = 1'b0;
		case (side_s2.cls)
			CLS_NAN: clip = 1'b1;
			CLS_ZERO: ;
			CLS_CLAMP: begin
				clip = 1'b1;
				val  = side_s2.neg ? 16'h8000 : 16'h7FFF;
			end
			default: begin
				if (!k_s2[9]) begin
					clip = 1'b1;
					val  = side_s2.neg ? 16'h8000 : 16'h7FFF;
				end else if (sh >= 10'd40) begin
					val = 16'd0;
				end else if (!side_s2.neg && qx > lim_p) begin
					clip = 1'b1;
					val  = 16'h7FFF;
				end else if (side_s2.neg && qx > lim_n) begin
					clip = 1'b1;
					val  = 16'h8000;
				end else begin
					val = side_s2.neg ? (16'd0 - r[15:0]) : r[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) res_s3 <= {side_s2.last, clip, val};
	end
endmodule

>>> rtl/pcm_float32_to_int16.sv
// Path: accepted input is registered by multiply, round, convert, then sent out.
// Throughput: one item per cycle unless the master stalls; three register stages.
// A stall on the master side freezes all stages together; nothing is lost or repeated.
// Reset: arst_n asynchronous, active low, clears the stage valid bits only.
// ---------------------------------------------------------------------------
// pcm_float32_to_int16
// Float32 audio sample to signed 16-bit PCM, with clip flag and end marker.
// ---------------------------------------------------------------------------
module pcm_float32_to_int16 import pf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] sample_bits
	input  logic        s_tlast,  // block_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [15:0] pcm_value, [16] clipped, zero fill above
	output logic        m_tlast   // block_end_out
);
	`include "pcm_float32_to_int16_assert.svh"

	logic        en;
	logic        v_s1, v_s2, v_s3;
	side_t       side_s1, side_s2;
	logic [38:0] p_s1;
	logic [23:0] q_s2;
	logic [9:0]  k_s2;
	logic [17:0] res_s3;

	// whole pipe advances when output slot is free or being taken
	assign en       = !v_s3 || m_tready;
	assign s_tready = en;

	pf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(s_tvalid),
		.sample_bits(s_tdata), .block_end(s_tlast),
		.v_s1(v_s1), .side_s1(side_s1), .p_s1(p_s1)
	);

	pf_rnd u_rnd (
		.clk(clk), .arst_n(arst_n), .en(en), .v_s1(v_s1), .side_s1(side_s1),
		.p_s1(p_s1), .v_s2(v_s2), .side_s2(side_s2), .q_s2(q_s2), .k_s2(k_s2)
	);

	pf_out u_out (
		.clk(clk), .arst_n(arst_n), .en(en), .v_s2(v_s2), .side_s2(side_s2),
		.q_s2(q_s2), .k_s2(k_s2), .v_s3(v_s3), .res_s3(res_s3)
	);

	assign m_tvalid = v_s3;
	assign m_tdata  = {7'd0, res_s3[16:0]};
	assign m_tlast  = res_s3[17];

	// a held output stays put while stalled
	`PF_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
	// stage 2 item reaches the output in the next cycle when advancing
	`PF_ASSERT_NXT(a_flow, clk, arst_n, v_s2 && en, m_tvalid, "item lost between stages")
	// NaN class must always flag
	`PF_ASSERT_NXT(a_nan, clk, arst_n, v_s2 && en && side_s2.cls == CLS_NAN, m_tdata[16] && m_tdata[15:0] == 16'd0, "NaN not flagged")
endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Float32 to int16 PCM converter: directed and random samples fed in bursts,
// random output stalls, each result checked against an integer predictor.
// ---------------------------------------------------------------------------
module tb_top;
	import pf_pkg::*;

	typedef struct packed {
		logic [31:0] bits;
		logic        last;
	} sample_t;

	typedef struct packed {
		logic [15:0] pcm;
		logic        clip;
		logic        last;
	} pcm_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	sample_t pending_q[$];
	pcm_t    pcm_expect_q[$];
	int      mismatches;
	int      cycles;
	int      burst_left;
	int      gap_left;
	bit      hold_sender;

	localparam int LIMIT = 200000;

	pcm_float32_to_int16 dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// scale by 32767, round to single (RNE), then to integer half away, clamp
	function automatic pcm_t convert_sample(sample_t s);
		pcm_t        r;
		logic        neg;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [63:0] p, q, rem, half, mag;
		int          drop, k, sh;
		neg = s.bits[31];
		ex  = s.bits[30:23];
		fr  = s.bits[22:0];
		r.pcm = 16'd0;
		r.clip = 1'b0;
		r.last = s.last;
		if (ex == 8'hFF) begin
			if (fr != 0) r.clip = 1'b1;
			else begin
				r.pcm = neg ? 16'h8000 : 16'h7FFF;
				r.clip = 1'b1;
			end
			return r;
		end
		if (ex == 8'd0) return r;
		if (ex > 8'd142) begin
			r.pcm = neg ? 16'h8000 : 16'h7FFF;
			r.clip = 1'b1;
			return r;
		end
		p = {40'd0, 1'b1, fr} * 64'd32767;
		drop = (p >> 38) != 0 ? 15 : 14;
		q = p >> drop;
		rem = p & ((64'd1 << drop) - 1);
		half = 64'd1 << (drop - 1);
		if (rem > half || (rem == half && q[0])) q = q + 1;
		if (q == (64'd1 << 24)) begin
			q = q >> 1;
			drop++;
		end
		k = drop + int'(ex) - 150;
		if (k >= 0) begin
			r.pcm = neg ? 16'h8000 : 16'h7FFF;
			r.clip = 1'b1;
			return r;
		end
		sh = -k;
		if (sh >= 40) return r;
		if (!neg && q > (64'd32767 << sh)) begin
			r.pcm = 16'h7FFF;
			r.clip = 1'b1;
			return r;
		end
		if (neg && q > (64'd32768 << sh)) begin
			r.pcm = 16'h8000;
			r.clip = 1'b1;
			return r;
		end
		mag = (q + (64'd1 << (sh - 1))) >> sh;
		r.pcm = neg ? 16'(17'h10000 - mag[16:0]) : mag[15:0];
		return r;
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int      pick;
		pick = $urandom_range(0, 9);
		s.bits = $urandom;
		s.last = 1'($urandom_range(0, 1));
		// mostly audio range; exponents near 2^-15 probe the rounding edge
		if (pick < 6) s.bits[30:23] = 8'($urandom_range(100, 127));
		else if (pick == 6) s.bits[30:23] = 8'($urandom_range(127, 143));
		else if (pick == 7) s.bits[30:23] = 8'($urandom_range(95, 112));
		return s;
	endfunction

	// driver: bursts with gaps, optional hold until the pipe drains
	// the item on the bus is always the head of pending_q
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pcm_expect_q.push_back(convert_sample({s_tdata, s_tlast}));
				pending_q.pop_front();
			end
			if (s_tvalid && !s_tready) begin
				// hold item
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (hold_sender || pending_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				sample_t nxt;
				nxt = pending_q[0];
				s_tvalid <= 1'b1;
				s_tdata <= nxt.bits;
				s_tlast <= nxt.last;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// monitor: own stall pattern, compare against oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mismatches <= 0;
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			m_tready <= (cycles[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (m_tvalid && m_tready) begin
				if (pcm_expect_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected item: pcm %h clip %b last %b",
							m_tdata[15:0], m_tdata[16], m_tlast);
					mismatches <= mismatches + 1;
				end else begin
					pcm_t e;
					e = pcm_expect_q.pop_front();
					if (m_tdata[15:0] !== e.pcm || m_tdata[16] !== e.clip ||
							m_tdata[23:17] !== 7'd0 || m_tlast !== e.last) begin
						if (mismatches < 10)
							$display("mismatch: exp pcm %h clip %b last %b, got %h %b %b",
								e.pcm, e.clip, e.last, m_tdata[15:0], m_tdata[16], m_tlast);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cycles > LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		sample_t s;
		logic [31:0] directed[$];
		hold_sender = 1'b0;
		arst_n = 1'b0;
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
			32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
			32'h3F80_0001, 32'hBF80_0001, 32'h3F00_0000, 32'hBF00_0000,
			32'h3800_0000, 32'hB800_0000, 32'h3880_0000, 32'h4700_0000,
			32'hC700_0000, 32'h3F7F_FFFF, 32'h0080_0000, 32'h7F80_0001};
		foreach (directed[i]) begin
			s.bits = directed[i];
			s.last = i[0];
			pending_q.push_back(s);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_q.size() == 0);
		// drain completely before random part
		@(posedge clk);
		hold_sender = 1'b1;
		wait (pcm_expect_q.size() == 0 && !s_tvalid);
		@(posedge clk);
		hold_sender = 1'b0;
		repeat (750) pending_q.push_back(rand_sample());
		wait (pending_q.size() == 0);
		wait (pcm_expect_q.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pcm_expect_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/pf_pkg.sv
rtl/pf_mul.sv
rtl/pf_rnd.sv
rtl/pf_out.sv
rtl/pcm_float32_to_int16.sv
test/tb_top.sv
